@@ sv/rtbc_pkg.sv @@
package rtbc_pkg;

    typedef struct packed {
        logic        mode;
        logic [31:0] req_us;
    } rtbc_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] total_us;
        logic [15:0] new_final_code;
    } rtbc_out_t;

    // register indexes
    localparam logic [2:0] REG_STEP_EN   = 3'd0;
    localparam logic [2:0] REG_PRE_PER   = 3'd1;
    localparam logic [2:0] REG_FIN_PER   = 3'd2;
    localparam logic [2:0] REG_SHORT_TO  = 3'd3;
    localparam logic [2:0] REG_PRE_TO    = 3'd4;
    localparam logic [2:0] REG_FIN_TO    = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FIN  = 2'd1;
    localparam logic [1:0] ST_BELOW   = 2'd2;
    localparam logic [1:0] ST_SMALL   = 2'd3;

    localparam logic [31:0] MIN_REQ_US = 32'd20000;

    // datapath operation codes
    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_SETUP  = 3'd1;
    localparam logic [2:0] OP_CONV   = 3'd2;
    localparam logic [2:0] OP_DIVSTP = 3'd3;
    localparam logic [2:0] OP_SUM    = 3'd4;
    localparam logic [2:0] OP_FIT    = 3'd5;
    localparam logic [2:0] OP_NORM   = 3'd6;

    // conversion selects
    localparam logic [2:0] SEL_SHORT = 3'd0;
    localparam logic [2:0] SEL_PRE   = 3'd1;
    localparam logic [2:0] SEL_FIN   = 3'd2;
    localparam logic [2:0] SEL_FIT   = 3'd3;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] sel;
    } rtbc_cmd_t;

    typedef struct packed {
        logic norm_done;
        logic mode;
    } rtbc_stat_t;

    // macro period in ns from a period code
    function automatic logic [31:0] macro_ns(input logic [7:0] code);
        logic [7:0]  per;
        logic [11:0] frac;
        logic [22:0] frac_prod;
        begin
            per       = 8'((9'(code) + 9'd1) << 1);
            // 2304 * 1655 / 1000 = 3813.12: whole part plus the rounded
            // fraction (12 * per + 50) / 100, done by reciprocal multiply
            frac      = 12'(per) * 12'd12 + 12'd50;
            frac_prod = 23'(frac) * 23'd1311;
            macro_ns  = 32'(per) * 32'd3813 + 32'(frac_prod[22:17]);
        end
    endfunction

    function automatic logic [15:0] decode_to(input logic [15:0] code);
        logic [15:0] sh;
        begin
            sh = (code[15:8] < 8'd16) ? 16'({8'd0, code[7:0]} << code[11:8]) : 16'd0;
            decode_to = sh + 16'd1;
        end
    endfunction

endpackage

@@ sv/ranging_timing_budget_calc.sv @@
// Ranging timing budget calculator.
// Mode 1 adds to the mode 0 sequence the 32-step restoring divide of the fit
// plus up to 24 normalizing shifts.
// Throughput: one transaction at a time; a new start is taken the cycle after done.
// Reset: asynchronous active low; registers return to their defaults.
// The receiver cannot stall: each result shows for one cycle with done.
module ranging_timing_budget_calc
    import rtbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  rtbc_in_t   in_item,
    output logic       done,
    output rtbc_out_t  result,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [15:0] cfg_data
);

    logic [7:0]  step_en_reg, pre_per_reg, fin_per_reg, short_to_reg;
    logic [15:0] pre_to_reg, fin_to_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_en_reg  <= 8'd232;
            pre_per_reg  <= 8'd6;
            fin_per_reg  <= 8'd4;
            short_to_reg <= 8'd0;
            pre_to_reg   <= 16'd0;
            fin_to_reg   <= 16'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STEP_EN:  step_en_reg  <= cfg_data[7:0];
                REG_PRE_PER:  pre_per_reg  <= cfg_data[7:0];
                REG_FIN_PER:  fin_per_reg  <= cfg_data[7:0];
                REG_SHORT_TO: short_to_reg <= cfg_data[7:0];
                REG_PRE_TO:   pre_to_reg   <= cfg_data;
                REG_FIN_TO:   fin_to_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    rtbc_cmd_t  cmd;
    rtbc_stat_t stat;

    rtbc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    rtbc_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_item  (in_item),
        .step_en  (step_en_reg),
        .pre_per  (pre_per_reg),
        .fin_per  (fin_per_reg),
        .short_to (short_to_reg),
        .pre_to   (pre_to_reg),
        .fin_to   (fin_to_reg),
        .stat     (stat),
        .res      (result)
    );

endmodule

@@ sv/rtbc_ctrl.sv @@
module rtbc_ctrl
    import rtbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  rtbc_stat_t stat,
    output logic       busy,
    output logic       done,
    output rtbc_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_FIT  = 3'd4;
    localparam logic [2:0] S_NORM = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [2:0] sel_reg, sel_next;

    // step through conversions: short, pre, final (us), then sum; in mode 1 also fit divide and normalize
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        cmd        = '{op: OP_NONE, sel: sel_reg};
        done       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_SETUP;
                    sel_next   = SEL_SHORT;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                cmd.op     = OP_CONV;
                cnt_next   = 6'd0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op   = OP_DIVSTP;
                cnt_next = cnt_reg + 6'd1;
                // unit conversions take a single step here, the fit divide 32 restoring steps
                unique case (sel_reg)
                    SEL_SHORT:
                    begin
                        sel_next   = SEL_PRE;
                        state_next = S_CONV;
                    end
                    SEL_PRE:
                    begin
                        sel_next   = SEL_FIN;
                        state_next = S_CONV;
                    end
                    SEL_FIN:
                    begin
                        state_next = S_SUM;
                    end
                    SEL_FIT:
                    begin
                        if (cnt_reg == 6'd31)
                            state_next = S_NORM;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SUM:
            begin
                cmd.op = OP_SUM;
                if (stat.mode)
                    state_next = S_FIT;
                else
                    state_next = S_DONE;
            end
            S_FIT:
            begin
                cmd.op     = OP_FIT;
                sel_next   = SEL_FIT;
                state_next = S_CONV;
            end
            S_NORM:
            begin
                cmd.op = OP_NORM;
                if (stat.norm_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 6'd0;
            sel_reg   <= SEL_SHORT;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

@@ sv/rtbc_dp.sv @@
module rtbc_dp
    import rtbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  rtbc_cmd_t   cmd,
    input  rtbc_in_t    in_item,
    input  logic [7:0]  step_en,
    input  logic [7:0]  pre_per,
    input  logic [7:0]  fin_per,
    input  logic [7:0]  short_to,
    input  logic [15:0] pre_to,
    input  logic [15:0] fin_to,
    output rtbc_stat_t  stat,
    output rtbc_out_t   res
);

    logic        mode_reg;
    logic [31:0] req_reg;
    logic [31:0] pre_mns_reg, fin_mns_reg;
    logic [15:0] pre_clk_reg, fin_clk_reg;
    logic [31:0] short_us_reg, pre_us_reg, fin_us_reg;
    logic [31:0] num_reg, den_reg, quo_reg, rem_reg;
    logic [1:0]  status_reg;
    logic [31:0] budget_reg;
    logic [31:0] ls_reg;
    logic [7:0]  ms_reg;
    logic        zero_reg;
    logic        div0_reg;

    logic tcc, dss, msrc, pre, fin;
    assign tcc  = step_en[4];
    assign dss  = step_en[3];
    assign msrc = step_en[2];
    assign pre  = step_en[6];
    assign fin  = step_en[7];

    // dividend for the selected conversion
    logic [31:0] clk_sel, mns_sel, conv_num;
    always_comb
    begin
        unique case (cmd.sel)
            SEL_SHORT: clk_sel = 32'(short_to) + 32'd1;
            SEL_PRE:   clk_sel = 32'(pre_clk_reg);
            default:   clk_sel = 32'(fin_clk_reg);
        endcase
        mns_sel = (cmd.sel == SEL_FIN) ? fin_mns_reg : pre_mns_reg;
        if (cmd.sel == SEL_FIT)
            conv_num = num_reg;
        else
            conv_num = clk_sel * mns_sel + (mns_sel >> 1);
    end

    // divide by 1000 through the reciprocal 2^38 / 1000, exact for 32 bits
    logic [60:0] recip_prod;
    logic [31:0] us_val;
    assign recip_prod = 61'(num_reg) * 61'd274877907;
    assign us_val     = {9'd0, recip_prod[60:38]};

    // restoring divide step
    logic [32:0] rem_sh, rem_sub;
    assign rem_sh  = {rem_reg, num_reg[31]};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    // sum of step times
    logic [31:0] used;
    always_comb
    begin
        used = (mode_reg ? 32'd1320 : 32'd1910) + 32'd960;
        if (tcc)
            used = used + short_us_reg + 32'd590;
        if (dss)
            used = used + ((short_us_reg + 32'd690) << 1);
        else if (msrc)
            used = used + short_us_reg + 32'd660;
        if (pre)
            used = used + pre_us_reg + 32'd660;
    end

    logic [31:0] used_fin, rest;
    assign used_fin = used + 32'd550;
    assign rest     = req_reg - used_fin;

    logic [31:0] clk_tot;
    assign clk_tot = (div0_reg ? 32'hFFFFFFFF : quo_reg)
                     + (pre ? 32'(pre_clk_reg) : 32'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            req_reg      <= 32'd0;
            pre_mns_reg  <= 32'd0;
            fin_mns_reg  <= 32'd0;
            pre_clk_reg  <= 16'd0;
            fin_clk_reg  <= 16'd0;
            short_us_reg <= 32'd0;
            pre_us_reg   <= 32'd0;
            fin_us_reg   <= 32'd0;
            num_reg      <= 32'd0;
            den_reg      <= 32'd0;
            quo_reg      <= 32'd0;
            rem_reg      <= 32'd0;
            status_reg   <= ST_OK;
            budget_reg   <= 32'd0;
            ls_reg       <= 32'd0;
            ms_reg       <= 8'd0;
            zero_reg     <= 1'b0;
            div0_reg     <= 1'b0;
        end
        else
        begin
            unique case (cmd.op)
                OP_SETUP:
                begin
                    mode_reg    <= in_item.mode;
                    req_reg     <= in_item.req_us;
                    pre_mns_reg <= macro_ns(pre_per);
                    fin_mns_reg <= macro_ns(fin_per);
                    pre_clk_reg <= decode_to(pre_to);
                    fin_clk_reg <= pre ? (decode_to(fin_to) - decode_to(pre_to))
                                       : decode_to(fin_to);
                    status_reg  <= ST_OK;
                    budget_reg  <= 32'd0;
                    ms_reg      <= 8'd0;
                    zero_reg    <= 1'b0;
                end
                OP_CONV:
                begin
                    num_reg  <= conv_num;
                    den_reg  <= fin_mns_reg;
                    div0_reg <= (fin_mns_reg == 32'd0);
                    rem_reg  <= 32'd0;
                end
                OP_DIVSTP:
                begin
                    if (cmd.sel == SEL_FIT)
                    begin
                        num_reg <= {num_reg[30:0], 1'b0};
                        if (!rem_sub[32])
                        begin
                            rem_reg <= rem_sub[31:0];
                            quo_reg <= {quo_reg[30:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh[31:0];
                            quo_reg <= {quo_reg[30:0], 1'b0};
                        end
                    end
                    // store the step time in us
                    else if (cmd.sel == SEL_SHORT)
                        short_us_reg <= us_val;
                    else if (cmd.sel == SEL_PRE)
                        pre_us_reg <= us_val;
                    else
                        fin_us_reg <= us_val;
                end
                OP_SUM:
                begin
                    if (!mode_reg)
                        budget_reg <= fin ? (used + fin_us_reg + 32'd550) : used;
                    else if (req_reg < MIN_REQ_US)
                        status_reg <= ST_BELOW;
                    else if (!fin)
                        status_reg <= ST_NO_FIN;
                    else if (used_fin > req_reg)
                        status_reg <= ST_SMALL;
                end
                OP_FIT:
                begin
                    num_reg <= rest * 32'd1000 + (fin_mns_reg >> 1);
                end
                OP_NORM:
                begin
                    if (ms_reg == 8'd0 && !zero_reg)
                    begin
                        zero_reg <= (clk_tot == 32'd0);
                        ls_reg   <= clk_tot - 32'd1;
                        ms_reg   <= 8'd1;
                    end
                    else if (ls_reg[31:8] != 24'd0)
                    begin
                        ls_reg <= ls_reg >> 1;
                        ms_reg <= ms_reg + 8'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // normalization finished once mantissa fits a byte
    assign stat.norm_done = (ms_reg != 8'd0) && (ls_reg[31:8] == 24'd0);
    assign stat.mode      = mode_reg;

    logic fit_ok;
    assign fit_ok = mode_reg && (status_reg == ST_OK);

    always_comb
    begin
        res.status         = status_reg;
        res.total_us       = mode_reg ? (fit_ok ? req_reg : 32'd0) : budget_reg;
        res.new_final_code = (fit_ok && !zero_reg)
                             ? {ms_reg - 8'd1, ls_reg[7:0]} : 16'd0;
    end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import rtbc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    rtbc_in_t    in_item;
    logic        done;
    rtbc_out_t   result;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    ranging_timing_budget_calc dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_item   (in_item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow copy of the configuration registers
    logic [7:0]  sh_step_en;
    logic [7:0]  sh_pre_per;
    logic [7:0]  sh_fin_per;
    logic [7:0]  sh_short_to;
    logic [15:0] sh_pre_to;
    logic [15:0] sh_fin_to;

    rtbc_out_t   budget_queue[$];
    int          n_errors;

    // clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // watchdog
    initial
    begin
        #400ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [31:0] pulse_to_macro_ns(input logic [7:0] code);
        logic [31:0] per;
        begin
            per = 32'(8'((32'(code) + 32'd1) * 32'd2));
            pulse_to_macro_ns = (32'd2304 * per * 32'd1655 + 32'd500) / 32'd1000;
        end
    endfunction

    function automatic logic [31:0] unpack_timeout(input logic [15:0] code);
        logic [31:0] sh;
        begin
            sh = (code[15:8] < 8'd16) ? ((32'(code[7:0]) << code[15:8]) & 32'hFFFF) : 32'd0;
            unpack_timeout = (sh + 32'd1) & 32'hFFFF;
        end
    endfunction

    function automatic logic [15:0] pack_timeout(input logic [31:0] clocks);
        logic [31:0] ls;
        logic [31:0] ms;
        begin
            ms = 0;
            if (clocks == 0)
                pack_timeout = 16'd0;
            else
            begin
                ls = clocks - 32'd1;
                while ((ls & 32'hFFFFFF00) != 0)
                begin
                    ls = ls >> 1;
                    ms = ms + 1;
                end
                pack_timeout = 16'(((ms << 8) | (ls & 32'hFF)));
            end
        end
    endfunction

    function automatic logic [31:0] clocks_us(input logic [31:0] clocks,
                                              input logic [31:0] mns);
        clocks_us = (clocks * mns + mns / 32'd2) / 32'd1000;
    endfunction

    // compute the expected budget result for one transaction
    function automatic rtbc_out_t predict_budget(input rtbc_in_t it);
        rtbc_out_t   r;
        logic        tcc, dss, msrc, pre, fin;
        logic [31:0] pre_mns, fin_mns, short_us, pre_clk, pre_us, fin_clk, used;
        logic [31:0] rest, clk_cnt;
        begin
            tcc      = sh_step_en[4];
            dss      = sh_step_en[3];
            msrc     = sh_step_en[2];
            pre      = sh_step_en[6];
            fin      = sh_step_en[7];
            pre_mns  = pulse_to_macro_ns(sh_pre_per);
            fin_mns  = pulse_to_macro_ns(sh_fin_per);
            short_us = clocks_us(32'(sh_short_to) + 32'd1, pre_mns);
            pre_clk  = unpack_timeout(sh_pre_to);
            pre_us   = clocks_us(pre_clk, pre_mns);
            fin_clk  = unpack_timeout(sh_fin_to);
            r        = '0;
            if (pre)
                fin_clk = (fin_clk - pre_clk) & 32'hFFFF;
            used = (it.mode == 1'b0 ? 32'd1910 : 32'd1320) + 32'd960;
            if (tcc)
                used += short_us + 32'd590;
            if (dss)
                used += 32'd2 * (short_us + 32'd690);
            else if (msrc)
                used += short_us + 32'd660;
            if (pre)
                used += pre_us + 32'd660;
            if (it.mode == 1'b0)
            begin
                if (fin)
                    used += clocks_us(fin_clk, fin_mns) + 32'd550;
                r.total_us = used;
            end
            else if (it.req_us < MIN_REQ_US)
                r.status = ST_BELOW;
            else if (!fin)
                r.status = ST_NO_FIN;
            else
            begin
                used += 32'd550;
                if (used > it.req_us)
                    r.status = ST_SMALL;
                else
                begin
                    rest = it.req_us - used;
                    if (fin_mns == 0)
                        clk_cnt = 32'hFFFFFFFF;
                    else
                        clk_cnt = (rest * 32'd1000 + fin_mns / 32'd2) / fin_mns;
                    if (pre)
                        clk_cnt += pre_clk;
                    r.new_final_code = pack_timeout(clk_cnt);
                    r.total_us       = it.req_us;
                end
            end
            predict_budget = r;
        end
    endfunction

    // check each result against the oldest expectation
    always @(posedge clk)
    begin : check_result
        rtbc_out_t want;
        if (rst_n && done)
        begin
            if (budget_queue.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                n_errors++;
            end
            else
            begin
                want = budget_queue.pop_front();
                if (result.status !== want.status)
                begin
                    $display("%0t: status exp %0d got %0d", $time, want.status,
                             result.status);
                    n_errors++;
                end
                if (result.total_us !== want.total_us)
                begin
                    $display("%0t: total_us exp %0d got %0d", $time, want.total_us,
                             result.total_us);
                    n_errors++;
                end
                if (result.new_final_code !== want.new_final_code)
                begin
                    $display("%0t: new_final_code exp %h got %h", $time,
                             want.new_final_code, result.new_final_code);
                    n_errors++;
                end
            end
        end
    end

    // wait for the block to drain before touching registers
    task automatic drain();
        while (budget_queue.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_STEP_EN:  sh_step_en  = val[7:0];
            REG_PRE_PER:  sh_pre_per  = val[7:0];
            REG_FIN_PER:  sh_fin_per  = val[7:0];
            REG_SHORT_TO: sh_short_to = val[7:0];
            REG_PRE_TO:   sh_pre_to   = val;
            REG_FIN_TO:   sh_fin_to   = val;
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [7:0] en, input logic [7:0] pp,
                               input logic [7:0] fp, input logic [7:0] st,
                               input logic [15:0] pt, input logic [15:0] ft);
        drain();
        write_reg(REG_STEP_EN, 16'(en));
        write_reg(REG_PRE_PER, 16'(pp));
        write_reg(REG_FIN_PER, 16'(fp));
        write_reg(REG_SHORT_TO, 16'(st));
        write_reg(REG_PRE_TO, pt);
        write_reg(REG_FIN_TO, ft);
        cfg_we <= 1'b0;
    endtask

    // send one transaction after a random gap
    task automatic send_request(input logic md, input logic [31:0] req);
        rtbc_in_t it;
        int       n;
        n = $urandom_range(0, 19);
        repeat (n) @(posedge clk);
        it.mode   = md;
        it.req_us = req;
        start   <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        budget_queue.push_back(predict_budget(it));
        start <= 1'b0;
        @(posedge clk);
    endtask

    // budget value: full range, around the 20000 minimum, near the maximum, or 20000 to 200000
    function automatic logic [31:0] pick_budget();
        case ($urandom_range(0, 5))
            0: pick_budget = $urandom;
            1: pick_budget = $urandom_range(0, 25000);
            2: pick_budget = 32'hFFFFFFFF - $urandom_range(0, 1000);
            default: pick_budget = $urandom_range(20000, 200000);
        endcase
    endfunction

    task automatic test_defaults();
        send_request(1'b0, 32'd0);
        send_request(1'b1, 32'd33000);
        send_request(1'b1, 32'd19999);
        send_request(1'b1, 32'd20000);
        send_request(1'b1, 32'hFFFFFFFF);
        send_request(1'b0, 32'hFFFFFFFF);
    endtask

    task automatic test_extremes();
        // all steps on, large exponent timeouts
        load_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_request(1'b0, 32'd0);
        send_request(1'b1, 32'd20000);
        send_request(1'b1, 32'hFFFFFFFF);
        // zero period on the final range
        load_config(8'hFF, 8'd3, 8'd127, 8'd10, 16'h0310, 16'h0520);
        send_request(1'b0, 32'd5);
        send_request(1'b1, 32'd50000);
        // final disabled, then everything off
        load_config(8'h7F, 8'd6, 8'd4, 8'd0, 16'h0000, 16'h0000);
        send_request(1'b1, 32'd40000);
        send_request(1'b1, 32'd100);
        load_config(8'h00, 8'd0, 8'd0, 8'd0, 16'h0000, 16'h0000);
        send_request(1'b0, 32'd0);
        send_request(1'b1, 32'd30000);
        // msrc without dss, zero final clocks
        load_config(8'hE4, 8'd14, 8'd10, 8'd30, 16'h0001, 16'h0001);
        send_request(1'b0, 32'd0);
        send_request(1'b1, 32'd20000);
        send_request(1'b1, 32'd25000);
    endtask

    task automatic test_random();
        int k;
        for (k = 0; k < 630; k++)
        begin
            if (k % 60 == 0)
                load_config(8'($urandom),
                            ($urandom_range(0, 7) == 0) ? 8'd127 : 8'($urandom),
                            ($urandom_range(0, 7) == 0) ? 8'd127
                                                        : 8'($urandom_range(0, 20)),
                            8'($urandom), {4'd0, 4'($urandom), 8'($urandom)},
                            ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                            {4'd0, 4'($urandom), 8'($urandom)});
            if (k == 300)
                drain();
            send_request(1'($urandom), pick_budget());
        end
    endtask

    initial
    begin
        n_errors  = 0;
        rst_n     = 1'b0;
        start     = 1'b0;
        in_item   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        sh_step_en  = 8'd232;
        sh_pre_per  = 8'd6;
        sh_fin_per  = 8'd4;
        sh_short_to = 8'd0;
        sh_pre_to   = 16'd0;
        sh_fin_to   = 16'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_extremes();
        test_random();

        drain();
        repeat (250) @(posedge clk);
        if (n_errors == 0 && budget_queue.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
